### src/rlfs_pkg.sv
// Shared types, codes and constants for the RGB LED fade sequencer.
package rlfs_pkg;

  localparam int unsigned DutyBitsDef = 8;
  localparam int unsigned MsBitsDef   = 16;

  // lamp modes
  localparam logic [1:0] MODE_WORK = 2'd0;
  localparam logic [1:0] MODE_FADE = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;
  localparam logic [1:0] MODE_WAKE = 2'd3;

  // channel indexes
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MS_TICK_LIMIT   = 3'd0;
  localparam logic [2:0] REG_HOLD_TO_OFF_MS  = 3'd1;
  localparam logic [2:0] REG_HOLD_TO_ON_MS   = 3'd2;
  localparam logic [2:0] REG_IDLE_TIMEOUT_MS = 3'd3;
  localparam logic [2:0] REG_STEP_PERIOD_MS  = 3'd4;
  localparam logic [2:0] REG_FADE_STEP_TICKS = 3'd5;
  localparam logic [2:0] REG_SETTLE_MS       = 3'd6;

  localparam logic [24:0] GAMMA_BIAS = 25'd130305;

  // handshake between sequencer and gamma unit
  typedef struct packed {
    logic       start;
    logic [7:0] value;
  } gam_req_t;

endpackage

### src/rgb_led_fade_sequencer.sv
// Top level of the RGB LED fade sequencer: tick control, fade sequencer, PWM output.
//
//  channel   | group           | payload (lowest bit first)
//  ----------+-----------------+---------------------------------------------------------
//  tick in   | s_axis_*        | tdata[0] button_down
//  result out| m_axis_*        | red_on, green_on, blue_on, red/green/blue_level, lamp_mode
//  config    | cfg_we/idx/wdata| register index 0..6, data up to 16 bits
//
// Each tick transaction is taken when the sequencer is idle. A tick that makes a colour
// step first runs its gamma values (up to three) one after another through the shared
// multiplier in the gamma unit; a tick without a colour step goes straight to the result.
// Reset puts the lamp in working mode with all counters and duties cleared.
// A stalled result holds in the output register; the next tick transaction is accepted
// meanwhile, and its result waits until the register frees.
module rgb_led_fade_sequencer import rlfs_pkg::*; #(
  parameter int unsigned DUTY_BITS = DutyBitsDef,
  parameter int unsigned MS_BITS   = MsBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] button_down
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] red_on [1] green_on [2] blue_on [10:3] red_level
                                      // [18:11] green_level [26:19] blue_level [28:27] lamp_mode
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_GSTART = 2'd1;
  localparam logic [1:0] ST_GWAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  typedef logic [DUTY_BITS-1:0] duty_t;
  typedef logic [MS_BITS-1:0]   ms_t;

  // configuration
  logic [7:0]  ms_tick_limit_q, step_period_ms_q, fade_step_ticks_q, settle_ms_q;
  logic [15:0] hold_to_off_ms_q, hold_to_on_ms_q, idle_timeout_ms_q;

  // control state
  logic [1:0] state_q, state_d;
  logic [1:0] mode_q, mode_d;
  duty_t      pwm_q;
  logic [7:0] tick_q, tick_d;
  ms_t        ms_q, ms_d, press_q, press_d;
  logic       held_q, held_d, last_q, last_d;
  logic [7:0] pos_q, pos_d;
  logic [2:0] phase_q, phase_d;
  logic [7:0] stepc_q, stepc_d;
  duty_t      duty_q [3];
  duty_t      duty_d [3];
  logic [1:0] fch_q, fch_d;
  logic [7:0] ftc_q, ftc_d, settle_q, settle_d;
  logic       skip_q, skip_d;

  // gamma job list for one colour step
  logic [1:0] njob_q, njob_d, jidx_q;
  logic [1:0] jch_q [3];
  logic [1:0] jch_d [3];
  logic [7:0] jv_q [3];
  logic [7:0] jv_d [3];

  logic        m_valid_q;
  logic [31:0] m_data_q;

  logic        accept, emit_go, ms_edge, cstep;
  logic [2:0]  sphase;
  logic [1:0]  fade_ch;
  logic [15:0] need;
  logic [7:0]  ci, cr, ch_half, c_half;
  gam_req_t    gam_req;
  logic        gam_done;
  duty_t       gam_res;
  logic [2:0]  pins;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit_go       = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  // fade order: red, blue, green
  always_comb begin
    unique case (fch_q)
      2'd0:    fade_ch = CH_R;
      2'd1:    fade_ch = CH_B;
      default: fade_ch = CH_G;
    endcase
  end

  // one tick of the lamp control, evaluated in the accept cycle
  always_comb begin
    mode_d   = mode_q;   tick_d   = tick_q;   ms_d   = ms_q;
    press_d  = press_q;  held_d   = held_q;   last_d = last_q;   pos_d   = pos_q;
    phase_d  = phase_q;  stepc_d  = stepc_q;  fch_d  = fch_q;    ftc_d   = ftc_q;
    settle_d = settle_q; skip_d   = 1'b0;     ms_edge = 1'b0;    cstep   = 1'b0;
    sphase   = phase_q;
    need     = hold_to_on_ms_q;
    for (int c = 0; c < 3; c++) duty_d[c] = duty_q[c];

    if (s_axis_tdata[0] != last_q) begin
      last_d = s_axis_tdata[0];
      if (s_axis_tdata[0]) begin
        held_d  = 1'b1;
        press_d = ms_q;
      end else begin
        held_d = 1'b0;
      end
      if (mode_q == MODE_DOWN) mode_d = MODE_WAKE;
    end else if (mode_q == MODE_DOWN) begin
      skip_d = 1'b1;
    end

    if (!skip_d) begin
      if (tick_q >= ms_tick_limit_q) begin
        tick_d  = '0;
        ms_d    = ms_q + ms_t'(1);
        ms_edge = 1'b1;
      end else begin
        tick_d = tick_q + 8'd1;
      end

      if (mode_d == MODE_FADE) begin
        if (fch_q != 2'd3) begin
          if (duty_q[fade_ch] == '0) begin
            fch_d = fch_q + 2'd1;
          end else begin
            ftc_d = ftc_q + 8'd1;
            if (ftc_d >= fade_step_ticks_q) begin
              ftc_d = '0;
              duty_d[fade_ch] = duty_q[fade_ch] - duty_t'(1);
            end
          end
        end else begin
          if (ms_edge && settle_q != 8'd255) settle_d = settle_q + 8'd1;
          if (settle_d >= settle_ms_q) mode_d = MODE_DOWN;
        end
      end else begin
        if (ms_d >= MS_BITS'(idle_timeout_ms_q) && mode_d != MODE_WAKE) begin
          mode_d = MODE_FADE; fch_d = '0; ftc_d = '0; settle_d = '0;
        end
        if (mode_d != MODE_FADE) begin
          need = (mode_d == MODE_WORK) ? hold_to_off_ms_q : hold_to_on_ms_q;
          if (held_d && ms_t'(ms_d - press_d) >= MS_BITS'(need)) begin
            held_d = 1'b0;
            if (mode_d == MODE_WORK) begin
              mode_d = MODE_FADE; fch_d = '0; ftc_d = '0; settle_d = '0;
            end else begin
              mode_d = MODE_WORK;
              ms_d   = '0;
            end
          end else if (mode_d == MODE_WORK) begin
            if (ms_edge) begin
              stepc_d = stepc_q + 8'd1;
              if (stepc_d >= step_period_ms_q) begin
                stepc_d = '0;
                cstep   = 1'b1;
                if (pos_q == 8'd255) begin
                  pos_d   = '0;
                  phase_d = phase_q + 3'd1;
                end else begin
                  pos_d = pos_q + 8'd1;
                end
                // phase seven sets no duty and folds back to phase zero
                sphase = phase_d;
                if (phase_d == 3'd7) phase_d = '0;
              end
            end
          end else if (!held_d) begin
            mode_d = MODE_FADE; fch_d = '0; ftc_d = '0; settle_d = '0;
          end
        end
      end
    end
  end

  // gamma jobs of the colour step
  assign ci      = pos_d;
  assign cr      = 8'd255 - pos_d;
  assign c_half  = {1'b0, pos_d[7:1]};
  assign ch_half = 8'd128 - c_half;

  always_comb begin
    njob_d = '0;
    for (int j = 0; j < 3; j++) begin
      jch_d[j] = CH_R;
      jv_d[j]  = '0;
    end
    if (cstep) begin
      unique case (sphase)
        3'd0: begin
          njob_d = 2'd2; jch_d[0] = CH_B; jv_d[0] = ci; jch_d[1] = CH_G; jv_d[1] = ch_half;
        end
        3'd1: begin
          njob_d = 2'd2; jch_d[0] = CH_B; jv_d[0] = cr; jch_d[1] = CH_R; jv_d[1] = ci;
        end
        3'd2: begin
          njob_d = 2'd2; jch_d[0] = CH_R; jv_d[0] = cr; jch_d[1] = CH_G; jv_d[1] = ci;
        end
        3'd3: begin
          njob_d = 2'd3; jch_d[0] = CH_G; jv_d[0] = cr; jch_d[1] = CH_B; jv_d[1] = ci;
          jch_d[2] = CH_R; jv_d[2] = ci;
        end
        3'd5: begin
          njob_d = 2'd3; jch_d[0] = CH_B; jv_d[0] = cr; jch_d[1] = CH_G; jv_d[1] = c_half;
          jch_d[2] = CH_R; jv_d[2] = ci;
        end
        3'd4, 3'd6: begin
          njob_d = 2'd1; jch_d[0] = CH_R; jv_d[0] = cr;
        end
        default: njob_d = '0;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = (njob_d != '0) ? ST_GSTART : ST_EMIT;
      ST_GSTART: state_d = ST_GWAIT;
      ST_GWAIT:  if (gam_done) state_d = (jidx_q == njob_q - 2'd1) ? ST_EMIT : ST_GSTART;
      ST_EMIT:   if (emit_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign gam_req.start = (state_q == ST_GSTART);
  assign gam_req.value = jv_q[jidx_q];

  rlfs_gamma #(
    .DUTY_BITS(DUTY_BITS)
  ) u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (gam_req),
    .done_o  (gam_done),
    .result_o(gam_res)
  );

  // pin drive from the updated duties; all off while powered down
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pins[c] = !skip_q && (duty_q[c] != '0) && (duty_q[c] >= pwm_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;  mode_q   <= MODE_WORK; pwm_q  <= '0;  tick_q <= '0;
      ms_q     <= '0;       press_q  <= '0;        held_q <= 1'b0; last_q <= 1'b0;
      pos_q    <= '0;       phase_q  <= '0;        stepc_q <= '0;
      fch_q    <= '0;       ftc_q    <= '0;        settle_q <= '0; skip_q <= 1'b0;
      njob_q   <= '0;       jidx_q   <= '0;        m_valid_q <= 1'b0;
      for (int c = 0; c < 3; c++) duty_q[c] <= '0;
      ms_tick_limit_q   <= 8'd36;    hold_to_off_ms_q  <= 16'd1200;
      hold_to_on_ms_q   <= 16'd150;  idle_timeout_ms_q <= 16'd35000;
      step_period_ms_q  <= 8'd3;     fade_step_ticks_q <= 8'd30;
      settle_ms_q       <= 8'd10;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MS_TICK_LIMIT:   ms_tick_limit_q   <= cfg_wdata_i[7:0];
          REG_HOLD_TO_OFF_MS:  hold_to_off_ms_q  <= cfg_wdata_i;
          REG_HOLD_TO_ON_MS:   hold_to_on_ms_q   <= cfg_wdata_i;
          REG_IDLE_TIMEOUT_MS: idle_timeout_ms_q <= cfg_wdata_i;
          REG_STEP_PERIOD_MS:  step_period_ms_q  <= cfg_wdata_i[7:0];
          REG_FADE_STEP_TICKS: fade_step_ticks_q <= cfg_wdata_i[7:0];
          REG_SETTLE_MS:       settle_ms_q       <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        mode_q <= mode_d;  tick_q <= tick_d;   ms_q <= ms_d;       press_q <= press_d;
        held_q <= held_d;  last_q <= last_d;   pos_q <= pos_d;     phase_q <= phase_d;
        stepc_q <= stepc_d; fch_q <= fch_d;    ftc_q <= ftc_d;     settle_q <= settle_d;
        skip_q <= skip_d;  njob_q <= njob_d;   jidx_q <= '0;
        for (int c = 0; c < 3; c++) duty_q[c] <= duty_d[c];
      end
      if (state_q == ST_GWAIT && gam_done) begin
        duty_q[jch_q[jidx_q]] <= gam_res;
        jidx_q <= jidx_q + 2'd1;
      end
      if (emit_go) begin
        m_valid_q <= 1'b1;
        if (!skip_q) pwm_q <= pwm_q + duty_t'(1);
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int j = 0; j < 3; j++) begin
        jch_q[j] <= jch_d[j];
        jv_q[j]  <= jv_d[j];
      end
    end
    if (emit_go) begin
      m_data_q <= {3'd0, mode_q, 8'(duty_q[CH_B]), 8'(duty_q[CH_G]), 8'(duty_q[CH_R]),
                   pins[CH_B], pins[CH_G], pins[CH_R]};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### src/rlfs_gamma.sv
// Multi-cycle cube gamma unit built around one shared 16x8 multiplier.
module rlfs_gamma import rlfs_pkg::*; #(
  parameter int unsigned DUTY_BITS = DutyBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gam_req_t             req_i,
  output logic                 done_o,
  output logic [DUTY_BITS-1:0] result_o
);

  localparam logic [1:0] CNT_IDLE = 2'd0;
  localparam logic [1:0] CNT_SQ   = 2'd1;
  localparam logic [1:0] CNT_CUBE = 2'd2;
  localparam logic [1:0] CNT_DONE = 2'd3;

  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  v_q;
  logic [23:0] prod_q;
  logic [15:0] mul_a;
  logic [23:0] mul_p;
  logic [24:0] sum;

  // first pass v*v, second pass v^2*v
  assign mul_a = (cnt_q == CNT_SQ) ? {8'd0, v_q} : prod_q[15:0];
  assign mul_p = 24'(mul_a) * 24'(v_q);

  always_comb begin
    unique case (cnt_q)
      CNT_IDLE: cnt_d = req_i.start ? CNT_SQ : CNT_IDLE;
      CNT_SQ:   cnt_d = CNT_CUBE;
      CNT_CUBE: cnt_d = CNT_DONE;
      CNT_DONE: cnt_d = CNT_IDLE;
      default:  cnt_d = CNT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_IDLE;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == CNT_IDLE && req_i.start) begin
      v_q <= req_i.value;
    end
    if (cnt_q == CNT_SQ || cnt_q == CNT_CUBE) begin
      prod_q <= mul_p;
    end
  end

  assign sum      = {1'b0, prod_q} + GAMMA_BIAS;
  assign done_o   = (cnt_q == CNT_DONE);
  assign result_o = (v_q < 8'd2) ? '0 : DUTY_BITS'(sum[24:16]);

endmodule

### tb/sv/tb_rgb_led_fade_sequencer.sv
// Self-checking testbench for the RGB LED fade sequencer: directed table, then random ticks.
module tb_rgb_led_fade_sequencer;
  import rlfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [0] button_down
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // [0] red_on [1] green_on [2] blue_on [10:3] red_level
                                      // [18:11] green_level [26:19] blue_level [28:27] lamp_mode
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  rgb_led_fade_sequencer dut (.*);

  always #6 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] blue_lvl;
    logic [7:0] green_lvl;
    logic [7:0] red_lvl;
    logic       blue_pin;
    logic       green_pin;
    logic       red_pin;
  } lamp_out_t;

  // ---------------------------------------------------------------------------
  // Lamp model: its own copy of registers and state.
  // ---------------------------------------------------------------------------
  logic [7:0]  r_tick_lim, r_step_per, r_fade_ticks, r_settle;
  logic [15:0] r_hold_off, r_hold_on, r_idle;

  logic [1:0]  m_mode;
  logic [7:0]  m_pwm, m_tick, m_pos, m_step_ms, m_fade_cnt, m_settle_cnt;
  logic [15:0] m_ms, m_press;
  logic        m_held, m_last;
  logic [2:0]  m_phase;
  logic [7:0]  m_duty[3];
  logic [1:0]  m_fade_ch;

  lamp_out_t   lamp_q[$];     // expected lamp outputs, oldest first
  int          n_errors = 0;

  task automatic lamp_reset();
    r_tick_lim = 36; r_hold_off = 1200; r_hold_on = 150; r_idle = 35000;
    r_step_per = 3; r_fade_ticks = 30; r_settle = 10;
    m_mode = MODE_WORK; m_pwm = 0; m_tick = 0; m_ms = 0; m_press = 0;
    m_held = 0; m_last = 0; m_pos = 0; m_phase = 0; m_step_ms = 0;
    m_duty[0] = 0; m_duty[1] = 0; m_duty[2] = 0;
    m_fade_ch = 0; m_fade_cnt = 0; m_settle_cnt = 0;
  endtask

  function automatic logic [7:0] cube_gamma(logic [7:0] v);
    logic [31:0] c;
    c = 32'(v) * 32'(v) * 32'(v) + 32'd130305;
    return (v < 2) ? 8'd0 : c[23:16];
  endfunction

  function automatic void enter_fadeout();
    m_mode = MODE_FADE; m_fade_ch = 0; m_fade_cnt = 0; m_settle_cnt = 0;
  endfunction

  function automatic void color_step();
    logic [7:0] i, r;
    if (m_pos == 8'd255) begin
      m_pos = 0;
      m_phase = m_phase + 3'd1;
    end else begin
      m_pos = m_pos + 8'd1;
    end
    i = m_pos;
    r = 8'd255 - i;
    case (m_phase)
      3'd0: begin
        m_duty[CH_B] = cube_gamma(i); m_duty[CH_G] = cube_gamma(8'd128 - (i >> 1));
      end
      3'd1: begin m_duty[CH_B] = cube_gamma(r); m_duty[CH_R] = cube_gamma(i); end
      3'd2: begin m_duty[CH_R] = cube_gamma(r); m_duty[CH_G] = cube_gamma(i); end
      3'd3: begin
        m_duty[CH_G] = cube_gamma(r); m_duty[CH_B] = cube_gamma(i);
        m_duty[CH_R] = cube_gamma(i);
      end
      3'd4: m_duty[CH_R] = cube_gamma(r);
      3'd5: begin
        m_duty[CH_B] = cube_gamma(r); m_duty[CH_G] = cube_gamma(i >> 1);
        m_duty[CH_R] = cube_gamma(i);
      end
      3'd6: m_duty[CH_R] = cube_gamma(r);
      default: m_phase = 0;
    endcase
  endfunction

  function automatic void fadeout_tick(logic ms_edge);
    logic [1:0] ch;
    if (m_fade_ch < 3) begin
      // fade order: red, blue, green
      ch = (m_fade_ch == 0) ? CH_R : (m_fade_ch == 1) ? CH_B : CH_G;
      if (m_duty[ch] == 0) begin
        m_fade_ch = m_fade_ch + 2'd1;
      end else begin
        m_fade_cnt = m_fade_cnt + 8'd1;
        if (m_fade_cnt >= r_fade_ticks) begin
          m_fade_cnt = 0;
          m_duty[ch] = m_duty[ch] - 8'd1;
        end
      end
    end else begin
      if (ms_edge && m_settle_cnt < 8'd255) m_settle_cnt = m_settle_cnt + 8'd1;
      if (m_settle_cnt >= r_settle) m_mode = MODE_DOWN;
    end
  endfunction

  function automatic void mode_control(logic ms_edge);
    logic [15:0] need;
    if (m_ms >= r_idle && m_mode != MODE_WAKE) enter_fadeout();
    if (m_mode == MODE_FADE) return;
    need = (m_mode == MODE_WORK) ? r_hold_off : r_hold_on;
    if (m_held && (m_ms - m_press) >= need) begin
      m_held = 0;
      if (m_mode == MODE_WORK) enter_fadeout();
      else begin
        m_mode = MODE_WORK;
        m_ms = 0;
      end
      return;
    end
    if (m_mode == MODE_WORK) begin
      if (ms_edge) begin
        m_step_ms = m_step_ms + 8'd1;
        if (m_step_ms >= r_step_per) begin
          m_step_ms = 0;
          color_step();
        end
      end
    end else if (!m_held) begin
      enter_fadeout();
    end
  endfunction

  function automatic lamp_out_t lamp_tick(logic level);
    lamp_out_t o;
    logic ms_edge;
    logic frozen;
    ms_edge = 0;
    frozen = 0;
    o = '0;
    if (level != m_last) begin
      m_last = level;
      if (level) begin
        m_held = 1;
        m_press = m_ms;
      end else begin
        m_held = 0;
      end
      if (m_mode == MODE_DOWN) m_mode = MODE_WAKE;
    end else if (m_mode == MODE_DOWN) begin
      frozen = 1;   // powered down: counters freeze, pins off
    end
    if (!frozen) begin
      if (m_tick >= r_tick_lim) begin
        m_tick = 0;
        m_ms = m_ms + 16'd1;
        ms_edge = 1;
      end else begin
        m_tick = m_tick + 8'd1;
      end
      if (m_mode == MODE_FADE) fadeout_tick(ms_edge);
      else mode_control(ms_edge);
      o.red_pin   = (m_duty[CH_R] != 0) && (m_duty[CH_R] >= m_pwm);
      o.green_pin = (m_duty[CH_G] != 0) && (m_duty[CH_G] >= m_pwm);
      o.blue_pin  = (m_duty[CH_B] != 0) && (m_duty[CH_B] >= m_pwm);
      m_pwm = m_pwm + 8'd1;
    end
    o.red_lvl = m_duty[CH_R];
    o.green_lvl = m_duty[CH_G];
    o.blue_lvl = m_duty[CH_B];
    o.mode = m_mode;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling profile: 0 none, 1 sender idle 72%, 2 receiver stall 72%, 3 both 36%.
  // ---------------------------------------------------------------------------
  int  idle_pct_src = 0;
  int  idle_pct_snk = 0;
  int  hold_off_cycles = 0;     // receiver pressure stretch

  task automatic set_idling(int phase);
    case (phase)
      1: begin idle_pct_src = 72; idle_pct_snk = 0; end
      2: begin idle_pct_src = 0; idle_pct_snk = 72; end
      3: begin idle_pct_src = 36; idle_pct_snk = 36; end
      default: begin idle_pct_src = 0; idle_pct_snk = 0; end
    endcase
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= idle_pct_snk);
    end
  end

  // Checker: compare each result transaction with the oldest expectation.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    lamp_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[28:0];
      if (lamp_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = lamp_q.pop_front();
        if (got.red_pin !== want.red_pin) begin
          $error("red_on exp %0d got %0d", want.red_pin, got.red_pin); n_errors++;
        end
        if (got.green_pin !== want.green_pin) begin
          $error("green_on exp %0d got %0d", want.green_pin, got.green_pin); n_errors++;
        end
        if (got.blue_pin !== want.blue_pin) begin
          $error("blue_on exp %0d got %0d", want.blue_pin, got.blue_pin); n_errors++;
        end
        if (got.red_lvl !== want.red_lvl) begin
          $error("red_level exp %0d got %0d", want.red_lvl, got.red_lvl); n_errors++;
        end
        if (got.green_lvl !== want.green_lvl) begin
          $error("green_level exp %0d got %0d", want.green_lvl, got.green_lvl); n_errors++;
        end
        if (got.blue_lvl !== want.blue_lvl) begin
          $error("blue_level exp %0d got %0d", want.blue_lvl, got.blue_lvl); n_errors++;
        end
        if (got.mode !== want.mode) begin
          $error("lamp_mode exp %0d got %0d", want.mode, got.mode); n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side (the long hold-off excluded).
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || hold_off_cycles > 0 || !rst_ni || (lamp_q.size() == 0 && !s_axis_tvalid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("** rgb_led_fade_sequencer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MS_TICK_LIMIT:   r_tick_lim = val[7:0];
      REG_HOLD_TO_OFF_MS:  r_hold_off = val;
      REG_HOLD_TO_ON_MS:   r_hold_on = val;
      REG_IDLE_TIMEOUT_MS: r_idle = val;
      REG_STEP_PERIOD_MS:  r_step_per = val[7:0];
      REG_FADE_STEP_TICKS: r_fade_ticks = val[7:0];
      REG_SETTLE_MS:       r_settle = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offer one tick; returns the model output of the accepted transaction.
  // tvalid stays up after acceptance; the idle loop or drain() drops it.
  task automatic send_tick(logic level, output lamp_out_t exp_o);
    while ($urandom_range(99) < idle_pct_src) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    exp_o = lamp_tick(level);
  endtask

  task automatic push_tick(logic level);
    lamp_out_t e;
    send_tick(level, e);
    lamp_q.push_back(e);
  endtask

  // Every tick yields a result, so idle means queue empty; then a small margin.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (lamp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Directed table: button level, expected output where obvious (check_fix).
  typedef struct {
    logic      level;
    bit        check_fix;
    lamp_out_t fix;
  } dir_row_t;

  // Random burst: mostly press/hold/release sequences with random lengths.
  task automatic random_burst(int n_items);
    int n;
    logic lvl;
    int run;
    n = 0;
    lvl = 1'b0;
    while (n < n_items) begin
      if ($urandom_range(9) < 8) begin
        lvl = ~lvl;
        run = ($urandom_range(3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 25);
      end else begin
        lvl = 1'($urandom_range(1));   // noise
        run = 1;
      end
      repeat (run) begin
        if (n < n_items) begin
          push_tick(lvl);
          n++;
        end
      end
    end
  endtask

  initial begin
    dir_row_t dir_tbl[$];
    lamp_out_t e;
    lamp_out_t zero_work;
    dir_row_t row;
    zero_work = '0;
    lamp_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first ticks after reset, then a press/release with fast timing
    // to cover hold-to-off, fade, power-down, wake and resume.
    cfg_write(REG_MS_TICK_LIMIT, 16'd0);
    cfg_write(REG_HOLD_TO_OFF_MS, 16'd4);
    cfg_write(REG_HOLD_TO_ON_MS, 16'd2);
    cfg_write(REG_IDLE_TIMEOUT_MS, 16'd65535);
    cfg_write(REG_STEP_PERIOD_MS, 16'd1);
    cfg_write(REG_FADE_STEP_TICKS, 16'd1);
    cfg_write(REG_SETTLE_MS, 16'd0);
    for (int k = 0; k < 24; k++) begin
      row.level = (k >= 2 && k < 8) || (k >= 14 && k < 20);
      // first tick: one ms, one colour step to position one; blue = gamma(1) = 0,
      // green = gamma(128) = 33 and lit against pwm count zero, still working
      row.check_fix = (k == 0);
      row.fix = zero_work;
      if (k == 0) begin
        row.fix.green_lvl = 8'd33;
        row.fix.green_pin = 1'b1;
      end
      dir_tbl.push_back(row);
    end
    foreach (dir_tbl[k]) begin
      send_tick(dir_tbl[k].level, e);
      lamp_q.push_back(dir_tbl[k].check_fix ? dir_tbl[k].fix : e);
    end
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      case (ph)
        0: begin
          cfg_write(REG_MS_TICK_LIMIT, 16'd1); cfg_write(REG_HOLD_TO_OFF_MS, 16'd30);
          cfg_write(REG_HOLD_TO_ON_MS, 16'd5); cfg_write(REG_IDLE_TIMEOUT_MS, 16'd400);
          cfg_write(REG_STEP_PERIOD_MS, 16'd1); cfg_write(REG_FADE_STEP_TICKS, 16'd1);
          cfg_write(REG_SETTLE_MS, 16'd3);
        end
        1: begin
          cfg_write(REG_MS_TICK_LIMIT, 16'd0); cfg_write(REG_HOLD_TO_OFF_MS, 16'd1);
          cfg_write(REG_HOLD_TO_ON_MS, 16'd1); cfg_write(REG_SETTLE_MS, 16'd255);
          cfg_write(REG_FADE_STEP_TICKS, 16'd255);
        end
        2: begin
          cfg_write(REG_MS_TICK_LIMIT, 16'd255); cfg_write(REG_STEP_PERIOD_MS, 16'd255);
          cfg_write(REG_HOLD_TO_OFF_MS, 16'd65535); cfg_write(REG_HOLD_TO_ON_MS, 16'd65535);
          cfg_write(REG_IDLE_TIMEOUT_MS, 16'd1); cfg_write(REG_FADE_STEP_TICKS, 16'd0);
          cfg_write(REG_SETTLE_MS, 16'd0);
        end
        3: begin
          cfg_write(REG_MS_TICK_LIMIT, 16'd0); cfg_write(REG_STEP_PERIOD_MS, 16'd0);
          cfg_write(REG_HOLD_TO_OFF_MS, 16'd50); cfg_write(REG_HOLD_TO_ON_MS, 16'd3);
          cfg_write(REG_IDLE_TIMEOUT_MS, 16'd65535); cfg_write(REG_FADE_STEP_TICKS, 16'd2);
          cfg_write(REG_SETTLE_MS, 16'd1);
        end
        default: begin
          cfg_write(REG_MS_TICK_LIMIT, 16'($urandom_range(0, 3)));
          cfg_write(REG_HOLD_TO_OFF_MS, 16'($urandom_range(1, 80)));
          cfg_write(REG_HOLD_TO_ON_MS, 16'($urandom_range(1, 10)));
          cfg_write(REG_IDLE_TIMEOUT_MS, 16'($urandom_range(100, 65535)));
          cfg_write(REG_STEP_PERIOD_MS, 16'($urandom_range(0, 2)));
          cfg_write(REG_FADE_STEP_TICKS, 16'($urandom_range(0, 4)));
          cfg_write(REG_SETTLE_MS, 16'($urandom_range(0, 6)));
        end
      endcase
      // Long receiver hold-off while the sender keeps offering ticks.
      if (ph == 4) hold_off_cycles = 400;
      random_burst(235);
      drain();
    end

    if (n_errors == 0)
      $display("** rgb_led_fade_sequencer: PASSED **");
    else
      $display("** rgb_led_fade_sequencer: FAILED **");
    $finish;
  end

endmodule
